>>> rtl/core/dtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared constants and types for the deadline timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;
    localparam int TIMER_SLOTS = 32;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
    localparam int RESULT_CAP  = (TIMER_SLOTS < 32) ? TIMER_SLOTS : 32;
    localparam logic [31:0] ROLLOVER_RESET = 32'd3600000;

    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_ADD     = 3'd0;
    localparam cmd_t CMD_CANCEL  = 3'd1;
    localparam cmd_t CMD_REFRESH = 3'd2;
    localparam cmd_t CMD_RESET   = 3'd3;
    localparam cmd_t CMD_QUERY   = 3'd4;
    localparam cmd_t CMD_COLLECT = 3'd5;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_INACTIVE = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_NONE     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,    // waiting for a request
        S_RDSLOT,  // memory read of addressed slot pending
        S_DECIDE,  // slot data available
        S_SCAN,    // sweep slots: earliest / front check
        S_SCAN2,   // last read data for sweep
        S_PICK,    // collect: sweep for next due slot
        S_PICK2,
        S_REARM,   // write back picked slot
        S_EMIT     // result waiting
    } state_t;
endpackage
`default_nettype wire

>>> rtl/core/deadline_timer_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_timer_table_unit
// Timer slot table with ordered deadlines held in a slot memory.
// ----------------------------------------------------------------------------
// One request at a time. The slot memory (one read port, registered read)
// is swept one slot per cycle wherever the earliest or the due deadlines are
// needed. Cancel, refresh, an add into a full table, a reset that needs no
// sweep and a collect on an empty table go from the slot read straight to the
// result; add, reset and query sweep the table once first. Collect sweeps
// for its first result (or its nothing-expired result) and sweeps again for
// each further due slot; a stalled result holds the next sweep. Results leave
// through an output register; a new request is taken the cycle after the last
// result is accepted.
module deadline_timer_table_unit (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_we,
    input  wire  [31:0]         cfg_wdata,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [2:0]          s_cmd,
    input  wire  [4:0]          s_slot_id,
    input  wire  [63:0]         s_period_ms,
    input  wire                 s_repeat_mode,
    input  wire                 s_from_now,
    input  wire  [63:0]         s_now_ms,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [1:0]          m_status,
    output logic [4:0]          m_timer_id,
    output logic [63:0]         m_wait_ms,
    output logic                m_front_notice,
    output logic                m_last
);
    import dtt_pkg::*;

    // slot memory: {recurring, period, deadline}
    logic [128:0] mem [TIMER_SLOTS];
    logic [128:0] rd_data;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [128:0]      wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    logic [TIMER_SLOTS-1:0] active_reg, active_next;
    logic [TIMER_SLOTS-1:0] done_reg, done_next;   // collect: already picked
    logic [31:0] roll_win_reg;
    logic [63:0] prev_now_reg, prev_now_next;
    logic        pend_reg, pend_next;
    state_t      state_reg, state_next;

    cmd_t        cmd_reg;
    logic [4:0]  sid_reg;
    logic [63:0] per_reg, now_reg;
    logic        rep_reg, fnow_reg;
    logic [SLOT_W-1:0] tgt_reg, tgt_next;       // slot under add/reset
    logic [63:0] tdl_reg, tdl_next;             // its deadline
    logic [CNT_W-1:0] cnt_reg, cnt_next;        // sweep address counter
    logic [SLOT_W-1:0] prv_reg, prv_next;       // address of rd_data
    logic        pv_reg, pv_next;               // rd_data belongs to sweep
    logic        bfound_reg, bfound_next;
    logic [SLOT_W-1:0] bidx_reg, bidx_next;
    logic [63:0] bdl_reg, bdl_next;
    logic        brec_reg, brec_next;
    logic [63:0] bper_reg, bper_next;
    logic        roll_reg, roll_next;
    logic [5:0]  nout_reg, nout_next;
    logic [CNT_W-1:0] dcnt_reg, dcnt_next;      // due slots not yet picked
    logic        early_reg, early_next;         // earlier slot seen in front check

    logic        ov_reg, ov_next;
    logic [1:0]  ost_reg, ost_next;
    logic [4:0]  oid_reg, oid_next;
    logic [63:0] ow_reg, ow_next;
    logic        ofn_reg, ofn_next, olast_reg, olast_next;

    // lowest free slot
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    wire sid_ok = ({27'd0, sid_reg} < 32'(TIMER_SLOTS));
    wire [SLOT_W-1:0] sidx = sid_reg[SLOT_W-1:0];
    wire [63:0] rd_dl  = rd_data[63:0];
    wire [63:0] rd_per = rd_data[127:64];
    wire        rd_rec = rd_data[128];
    wire        sweep_end = (cnt_reg == CNT_W'(TIMER_SLOTS));
    wire        rd_act = active_reg[prv_reg];
    wire        due_now = roll_reg || (rd_dl <= now_reg);
    // candidate from memory beats current best
    wire        cand_better = !bfound_reg || (rd_dl < bdl_reg) ||
                              (rd_dl == bdl_reg && prv_reg < bidx_reg);
    wire        beats_tgt = (rd_dl < tdl_reg) ||
                            (rd_dl == tdl_reg && prv_reg < tgt_reg);

    always_comb begin
        state_next   = state_reg;
        active_next  = active_reg;
        done_next    = done_reg;
        prev_now_next = prev_now_reg;
        pend_next    = pend_reg;
        tgt_next     = tgt_reg;
        tdl_next     = tdl_reg;
        cnt_next     = cnt_reg;
        prv_next     = prv_reg;
        pv_next      = 1'b0;
        bfound_next  = bfound_reg;
        bidx_next    = bidx_reg;
        bdl_next     = bdl_reg;
        brec_next    = brec_reg;
        bper_next    = bper_reg;
        roll_next    = roll_reg;
        nout_next    = nout_reg;
        dcnt_next    = dcnt_reg;
        early_next   = early_reg;
        ov_next      = ov_reg;
        ost_next     = ost_reg;
        oid_next     = oid_reg;
        ow_next      = ow_reg;
        ofn_next     = ofn_reg;
        olast_next   = olast_reg;
        wr_en        = 1'b0;
        wr_addr      = tgt_reg;
        wr_data      = '0;
        rd_addr      = sidx;
        if (ov_reg && m_ready) ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                rd_addr = s_slot_id[SLOT_W-1:0];
                if (s_valid && s_ready) begin
                    cnt_next = '0;
                    bfound_next = 1'b0;
                    early_next = 1'b0;
                    nout_next = '0;
                    dcnt_next = '0;
                    done_next = '0;
                    if (s_cmd == CMD_ADD || s_cmd == CMD_CANCEL || s_cmd == CMD_REFRESH ||
                        s_cmd == CMD_RESET || s_cmd == CMD_QUERY || s_cmd == CMD_COLLECT)
                        state_next = S_RDSLOT;
                end
            end
            S_RDSLOT: state_next = S_DECIDE;
            S_DECIDE: begin
                ost_next = ST_OK; oid_next = '0; ow_next = '0;
                ofn_next = 1'b0; olast_next = 1'b1;
                state_next = S_EMIT;
                unique case (cmd_reg)
                    CMD_ADD: begin
                        if (!free_any) ost_next = ST_FULL;
                        else begin
                            active_next[free_idx] = 1'b1;
                            wr_en = 1'b1; wr_addr = free_idx;
                            wr_data = {rep_reg, per_reg, now_reg + per_reg};
                            tgt_next = free_idx;
                            tdl_next = now_reg + per_reg;
                            oid_next = 5'(free_idx);
                            state_next = S_SCAN;
                        end
                    end
                    CMD_CANCEL: begin
                        if (!sid_ok || !active_reg[sidx]) ost_next = ST_INACTIVE;
                        else active_next[sidx] = 1'b0;
                    end
                    CMD_REFRESH: begin
                        if (!sid_ok || !active_reg[sidx]) ost_next = ST_INACTIVE;
                        else begin
                            wr_en = 1'b1; wr_addr = sidx;
                            wr_data = {rd_rec, rd_per, now_reg + rd_per};
                        end
                    end
                    CMD_RESET: begin
                        if (sid_ok && per_reg == rd_per && !fnow_reg) ost_next = ST_OK;
                        else if (!sid_ok || !active_reg[sidx]) ost_next = ST_INACTIVE;
                        else begin
                            wr_en = 1'b1; wr_addr = sidx;
                            tdl_next = (fnow_reg ? now_reg : rd_dl - rd_per) + per_reg;
                            wr_data = {rd_rec, per_reg,
                                       (fnow_reg ? now_reg : rd_dl - rd_per) + per_reg};
                            tgt_next = sidx;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_QUERY: begin
                        pend_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    default: begin // collect
                        if (active_reg == '0) ost_next = ST_NONE;
                        else begin
                            roll_next = (now_reg < prev_now_reg) &&
                                ((prev_now_reg - now_reg) > {32'd0, roll_win_reg});
                            prev_now_next = now_reg;
                            state_next = S_PICK;
                        end
                    end
                endcase
            end
            S_SCAN, S_PICK: begin
                // issue reads of every slot; evaluate the previous read
                rd_addr = cnt_reg[SLOT_W-1:0];
                if (pv_reg && rd_act) begin
                    if (state_reg == S_SCAN) begin
                        if (cand_better) begin
                            bfound_next = 1'b1; bidx_next = prv_reg; bdl_next = rd_dl;
                        end
                        if (prv_reg != tgt_reg && beats_tgt) early_next = 1'b1;
                    end else if (!done_reg[prv_reg] && due_now) begin
                        dcnt_next = dcnt_reg + 1'b1;
                        if (cand_better) begin
                            bfound_next = 1'b1; bidx_next = prv_reg; bdl_next = rd_dl;
                            brec_next = rd_rec; bper_next = rd_per;
                        end
                    end
                end
                if (sweep_end) begin
                    state_next = (state_reg == S_SCAN) ? S_SCAN2 : S_PICK2;
                end else begin
                    prv_next = cnt_reg[SLOT_W-1:0];
                    pv_next = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SCAN2: begin
                state_next = S_EMIT;
                if (cmd_reg == CMD_QUERY) begin
                    if (!bfound_reg) ow_next = '1;
                    else if (now_reg >= bdl_reg) ow_next = '0;
                    else ow_next = bdl_reg - now_reg;
                end else if (!early_reg && !pend_reg) begin
                    ofn_next = 1'b1;
                    pend_next = 1'b1;
                end
            end
            S_PICK2: begin
                if (!bfound_reg) begin
                    if (nout_reg == '0) begin
                        ost_next = ST_NONE; oid_next = '0; ow_next = '0;
                        ofn_next = 1'b0; olast_next = 1'b1;
                        state_next = S_EMIT;
                    end else state_next = S_IDLE;
                end else state_next = S_REARM;
            end
            S_REARM: begin
                // hold the emit until the previous result left; the pick is last when no
                // other due slot was counted in this sweep or the result cap is reached
                if (!ov_reg || m_ready) begin
                    done_next[bidx_reg] = 1'b1;
                    if (brec_reg) begin
                        wr_en = 1'b1; wr_addr = bidx_reg;
                        wr_data = {brec_reg, bper_reg, now_reg + bper_reg};
                    end else active_next[bidx_reg] = 1'b0;
                    ov_next = 1'b1;
                    ost_next = ST_OK; oid_next = 5'(bidx_reg); ow_next = '0;
                    ofn_next = 1'b0;
                    nout_next = nout_reg + 1'b1;
                    olast_next = 1'b0;
                    bfound_next = 1'b0;
                    dcnt_next = '0;
                    cnt_next = '0;
                    state_next = S_PICK;
                    if (dcnt_reg == CNT_W'(1) || nout_reg + 1'b1 == 6'(RESULT_CAP)) begin
                        olast_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (!ov_reg || m_ready) begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb s_ready = aresetn && (state_reg == S_IDLE) && !ov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            active_reg <= '0;
            roll_win_reg <= ROLLOVER_RESET;
            prev_now_reg <= '0;
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
            pv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            active_reg <= active_next;
            prev_now_reg <= prev_now_next;
            pend_reg <= pend_next;
            pv_reg <= pv_next;
            ov_reg <= ov_next;
            if (cfg_we) roll_win_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_cmd; sid_reg <= s_slot_id; per_reg <= s_period_ms;
            rep_reg <= s_repeat_mode; fnow_reg <= s_from_now; now_reg <= s_now_ms;
        end
        tgt_reg <= tgt_next; tdl_reg <= tdl_next; cnt_reg <= cnt_next;
        prv_reg <= prv_next; bfound_reg <= bfound_next; bidx_reg <= bidx_next;
        bdl_reg <= bdl_next; brec_reg <= brec_next; bper_reg <= bper_next;
        roll_reg <= roll_next; nout_reg <= nout_next; early_reg <= early_next;
        dcnt_reg <= dcnt_next;
        done_reg <= done_next;
        ost_reg <= ost_next; oid_reg <= oid_next; ow_reg <= ow_next;
        ofn_reg <= ofn_next; olast_reg <= olast_next;
    end

    assign m_valid = ov_reg;
    assign m_status = ost_reg;
    assign m_timer_id = oid_reg;
    assign m_wait_ms = ow_reg;
    assign m_front_notice = ofn_reg;
    assign m_last = olast_reg;

    // a result never carries a notice and a wait at once
    a_fn_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_front_notice |-> m_wait_ms == '0)
        else $error("front notice with nonzero wait");
    // no new request while a result is outstanding
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken with result pending");
    // a notice raises the pending flag
    a_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && m_front_notice |-> pend_reg)
        else $error("notice without pending flag");
endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for deadline_timer_table_unit. A queue of requests is
// built up front while a built-in timer table model predicts every result; a
// clocked driver and monitor move requests and results with random stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import dtt_pkg::*;

    // command codes the block ignores
    localparam cmd_t CMD_UNDEF_A = 3'd6;
    localparam cmd_t CMD_UNDEF_B = 3'd7;

    typedef struct {
        cmd_t        cmd;
        logic [4:0]  slot;
        logic [63:0] period;
        logic        rep;
        logic        fnow;
        logic [63:0] now;
    } req_t;

    typedef struct {
        status_t     status;
        logic [4:0]  id;
        logic [63:0] wait_ms;
        logic        notice;
        logic        last;
    } rsp_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_cmd = 0;
    logic [4:0]  s_slot_id = 0;
    logic [63:0] s_period_ms = 0;
    logic        s_repeat_mode = 0;
    logic        s_from_now = 0;
    logic [63:0] s_now_ms = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_status;
    logic [4:0]  m_timer_id;
    logic [63:0] m_wait_ms;
    logic        m_front_notice;
    logic        m_last;

    deadline_timer_table_unit uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_slot_id(s_slot_id),
        .s_period_ms(s_period_ms), .s_repeat_mode(s_repeat_mode),
        .s_from_now(s_from_now), .s_now_ms(s_now_ms),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_timer_id(m_timer_id), .m_wait_ms(m_wait_ms),
        .m_front_notice(m_front_notice), .m_last(m_last)
    );

    always #5 aclk = ~aclk;

    req_t        pending_reqs[$];
    rsp_t        expected_rsps[$];
    int          errors = 0;
    int          reqs_sent = 0;
    int          rsps_seen = 0;
    int          expired_seen = 0;
    int          rollovers = 0;
    bit          idle_on = 1;
    int          src_gap = 0;
    int          snk_gap = 0;

    // timer table shadow
    logic        act[32];
    logic        rec[32];
    logic [63:0] per[32];
    logic [63:0] dl[32];
    bit          written[32];
    logic [63:0] last_now = 0;
    logic        notice = 0;
    logic [31:0] window = ROLLOVER_RESET;
    logic [63:0] clk_ms = 1000;

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit ahead(int a, int b);
        return dl[a] < dl[b] || (dl[a] == dl[b] && a < b);
    endfunction

    function automatic logic front_chk(int s);
        for (int i = 0; i < 32; i++)
            if (i != s && act[i] && ahead(i, s)) return 0;
        if (notice) return 0;
        notice = 1;
        return 1;
    endfunction

    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < 32; i++)
            if (act[i] && (best < 0 || ahead(i, best))) best = i;
        return best;
    endfunction

    task automatic push_rsp(status_t st, int id, logic [63:0] w, logic fn, logic lst);
        rsp_t r;
        r.status = st; r.id = id[4:0]; r.wait_ms = w; r.notice = fn; r.last = lst;
        expected_rsps.insert(expected_rsps.size(), r);
    endtask

    // update the table shadow and queue the results one request causes
    task automatic table_step(req_t q);
        int s, e, n, best;
        logic [63:0] start, w;
        bit due[32];
        bit roll;
        int picked[32];
        s = q.slot;
        case (q.cmd)
            CMD_ADD: begin
                s = -1;
                for (int i = 0; i < 32 && s < 0; i++) if (!act[i]) s = i;
                if (s < 0) push_rsp(ST_FULL, 0, 0, 0, 1);
                else begin
                    act[s] = 1; rec[s] = q.rep; per[s] = q.period;
                    dl[s] = q.now + q.period; written[s] = 1;
                    push_rsp(ST_OK, s, 0, front_chk(s), 1);
                end
            end
            CMD_CANCEL: begin
                if (!act[s]) push_rsp(ST_INACTIVE, 0, 0, 0, 1);
                else begin
                    act[s] = 0;
                    push_rsp(ST_OK, 0, 0, 0, 1);
                end
            end
            CMD_REFRESH: begin
                if (!act[s]) push_rsp(ST_INACTIVE, 0, 0, 0, 1);
                else begin
                    dl[s] = q.now + per[s];
                    push_rsp(ST_OK, 0, 0, 0, 1);
                end
            end
            CMD_RESET: begin
                if (q.period == per[s] && !q.fnow) push_rsp(ST_OK, 0, 0, 0, 1);
                else if (!act[s]) push_rsp(ST_INACTIVE, 0, 0, 0, 1);
                else begin
                    start = q.fnow ? q.now : dl[s] - per[s];
                    per[s] = q.period;
                    dl[s] = start + q.period;
                    push_rsp(ST_OK, 0, 0, front_chk(s), 1);
                end
            end
            CMD_QUERY: begin
                e = earliest_slot();
                notice = 0;
                if (e < 0) w = '1;
                else if (q.now >= dl[e]) w = 0;
                else w = dl[e] - q.now;
                push_rsp(ST_OK, 0, w, 0, 1);
            end
            CMD_COLLECT: begin
                e = earliest_slot();
                if (e < 0) push_rsp(ST_NONE, 0, 0, 0, 1);
                else begin
                    roll = q.now < last_now && (last_now - q.now) > {32'd0, window};
                    if (roll) rollovers++;
                    last_now = q.now;
                    for (int i = 0; i < 32; i++) due[i] = act[i] && (roll || dl[i] <= q.now);
                    n = 0;
                    best = 0;
                    while (n < RESULT_CAP && best >= 0) begin
                        best = -1;
                        for (int i = 0; i < 32; i++)
                            if (due[i] && (best < 0 || ahead(i, best))) best = i;
                        if (best >= 0) begin
                            due[best] = 0;
                            picked[n] = best;
                            n++;
                        end
                    end
                    expired_seen += n;
                    if (n == 0) push_rsp(ST_NONE, 0, 0, 0, 1);
                    for (int k = 0; k < n; k++) begin
                        push_rsp(ST_OK, picked[k], 0, 0, k == n - 1);
                        if (rec[picked[k]]) dl[picked[k]] = q.now + per[picked[k]];
                        else act[picked[k]] = 0;
                    end
                end
            end
            default: ;  // unknown command, no result
        endcase
    endtask

    task automatic send(cmd_t c, int slot, logic [63:0] p, logic r, logic f,
                        logic [63:0] t);
        req_t q;
        // reset with keep-start reads the slot period: only on written slots
        if (c == CMD_RESET && !f && !written[slot]) f = 1;
        q.cmd = c; q.slot = slot[4:0]; q.period = p; q.rep = r; q.fnow = f; q.now = t;
        table_step(q);
        pending_reqs.insert(pending_reqs.size(), q);
        reqs_sent++;
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);  // an ignored request may still be in flight
    endtask

    task automatic set_window(logic [31:0] v);
        wait_idle();
        @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= v;
        window = v;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic rand_req(int add_bias);
        int c, pick, slot;
        logic [63:0] p;
        logic f;
        pick = $urandom_range(0, 99);
        if (pick < add_bias) c = CMD_ADD;
        else if (pick < add_bias + 8) c = CMD_CANCEL;
        else if (pick < add_bias + 18) c = CMD_REFRESH;
        else if (pick < add_bias + 33) c = CMD_RESET;
        else if (pick < add_bias + 45) c = CMD_QUERY;
        else if (pick < 97) c = CMD_COLLECT;
        else c = $urandom_range(0, 1) ? CMD_UNDEF_A : CMD_UNDEF_B;
        pick = $urandom_range(0, 99);
        if (pick < 3) clk_ms = clk_ms - {32'd0, $urandom};     // backward jump
        else if (pick < 5) clk_ms = rand64();
        else clk_ms = clk_ms + $urandom_range(0, 60);
        pick = $urandom_range(0, 99);
        if (pick < 70) p = $urandom_range(0, 100);
        else if (pick < 80) p = 0;
        else p = rand64();
        slot = $urandom_range(0, 31);
        if ($urandom_range(0, 9) < 7)
            for (int k = 0; k < 8 && !act[slot]; k++) slot = $urandom_range(0, 31);
        f = 1'($urandom_range(0, 1));
        if (c == CMD_RESET && written[slot] && $urandom_range(0, 2) == 0) begin
            p = per[slot];
            f = 0;
        end
        send(cmd_t'(c), slot, p, 1'($urandom_range(0, 1)), f, clk_ms);
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else if (!s_valid || s_ready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 0;
            end else if (idle_on && pending_reqs.size() != 0 && $urandom_range(0, 7) == 0) begin
                src_gap <= $urandom_range(1, 9) - 1;
                s_valid <= 0;
            end else if (pending_reqs.size() != 0) begin
                req_t q;
                q = pending_reqs.pop_front();
                s_cmd <= q.cmd; s_slot_id <= q.slot; s_period_ms <= q.period;
                s_repeat_mode <= q.rep; s_from_now <= q.fnow; s_now_ms <= q.now;
                s_valid <= 1;
            end else begin
                s_valid <= 0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                rsps_seen++;
                if (expected_rsps.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    rsp_t r;
                    r = expected_rsps.pop_front();
                    if (m_status !== r.status)
                        report($sformatf("status %0d exp %0d", m_status, r.status));
                    if (m_timer_id !== r.id)
                        report($sformatf("timer_id %0d exp %0d", m_timer_id, r.id));
                    if (m_wait_ms !== r.wait_ms)
                        report($sformatf("wait_ms %0h exp %0h", m_wait_ms, r.wait_ms));
                    if (m_front_notice !== r.notice)
                        report($sformatf("front_notice %0b exp %0b", m_front_notice, r.notice));
                    if (m_last !== r.last)
                        report($sformatf("last %0b exp %0b", m_last, r.last));
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                m_ready <= 0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                snk_gap <= $urandom_range(1, 9) - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    initial begin
        #20ms;
        $display("TIMEOUT: %0d results still expected", expected_rsps.size());
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        for (int i = 0; i < 32; i++) begin
            act[i] = 0; rec[i] = 0; per[i] = 0; dl[i] = 0; written[i] = 0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // directed: empty table, inactive slots, extremes, ties, notices
        send(CMD_QUERY,   0, 0, 0, 0, 0);
        send(CMD_COLLECT, 0, 0, 0, 0, 64'd50);
        send(CMD_CANCEL,  3, 0, 0, 0, 64'd60);
        send(CMD_REFRESH, 31, 0, 0, 0, 64'd60);
        send(CMD_RESET,   7, 64'd5, 0, 1, 64'd60);
        send(CMD_ADD,     0, 64'd0, 0, 0, 64'd100);
        send(CMD_ADD,     0, '1, 1, 1, 64'd100);          // deadline wraps
        send(CMD_ADD,     0, 64'd0, 1, 0, 64'd100);       // equal deadline
        send(CMD_QUERY,   0, 0, 0, 0, 64'd90);
        send(CMD_ADD,     0, 64'd0, 0, 0, 64'd80);        // new earliest
        send(CMD_RESET,   0, 64'd0, 0, 0, 64'd85);        // same period, keep start
        send(CMD_RESET,   1, 64'd40, 1, 0, 64'd85);
        send(CMD_RESET,   2, 64'd10, 0, 1, 64'd85);
        send(CMD_REFRESH, 0, 0, 0, 0, 64'd86);
        send(CMD_QUERY,   0, 0, 0, 0, '1);
        send(CMD_UNDEF_A, 5, '1, 1, 1, '1);
        send(CMD_UNDEF_B, 0, 0, 0, 0, 0);
        send(CMD_COLLECT, 0, 0, 0, 0, 64'd100);
        send(CMD_COLLECT, 0, 0, 0, 0, '1);
        send(CMD_CANCEL,  1, 0, 0, 0, '1);
        send(CMD_COLLECT, 0, 0, 0, 0, 64'd10);             // far backward: rollover
        send(CMD_CANCEL,  2, 0, 0, 0, 64'd10);

        // pause the sender until everything has drained
        wait_idle();

        set_window(32'd0);
        for (int i = 0; i < 36; i++)                       // fill past full
            send(CMD_ADD, 0, 64'($urandom_range(0, 20)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), clk_ms);
        send(CMD_COLLECT, 0, 0, 0, 0, clk_ms + 64'd20);     // all 32 due
        for (int i = 0; i < 40; i++) rand_req(40);

        set_window(32'hFFFFFFFF);
        for (int i = 0; i < 40; i++) rand_req(30);

        set_window($urandom);
        for (int i = 0; i < 40; i++) rand_req(30);

        set_window(ROLLOVER_RESET);
        idle_on = 0;
        for (int i = 0; i < 40; i++) rand_req(30);

        wait_idle();
        if (expected_rsps.size() != 0) report("results left over at end");
        $display("%0d requests, %0d results (%0d expiries, %0d rollover collects)",
                 reqs_sent, rsps_seen, expired_seen, rollovers);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/dtt_pkg.sv
rtl/core/deadline_timer_table_unit.sv
dv/tb_top.sv
